// ===== hdl/mppm_pkg.sv =====
// Shared types and constants for the multi-prefix path matcher.
// No dependencies; every other file in hdl imports this package.
package mppm_pkg;

  localparam int RULES      = 16;
  localparam int RULE_BYTES = 64;

  // Fixed field widths of the item ports
  localparam int IDX_W  = 4;
  localparam int BPOS_W = 6;
  localparam int DATA_W = 8;

  // Prefix lengths and path position hold 0..RULE_BYTES
  localparam int LEN_W  = $clog2(RULE_BYTES + 1);
  // Address of one byte within a rule bank
  localparam int ADDR_W = (RULE_BYTES > 1) ? $clog2(RULE_BYTES) : 1;

  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_SET_LEN = 2'd1,
    OP_PATH    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // One item as it stands in the compare stage
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len;      // saturated new length
    logic [DATA_W-1:0] data;
    logic              last;
    logic              consume;  // path byte is compared and counted
    logic [LEN_W-1:0]  pos;      // path position before this byte
  } item_t;

endpackage

// ===== hdl/multi_prefix_path_matcher.sv =====
// Top level of the multi-prefix path matcher: input stage, rule banks,
// compare stage and result register. Depends on mppm_pkg, mppm_bank, mppm_match.
//
// The block holds up to RULES disallowed path prefixes of up to RULE_BYTES
// bytes each and checks a streamed path against all of them side by side.
// Every item is one of: write a rule byte, set a rule length (saturated to
// RULE_BYTES, zero disables the rule), clear all rule lengths, or a path byte.
// A path item with last set gives one result: allowed, or the lowest index of
// a rule whose whole prefix equals the start of the path. An empty path is a
// path item with no_byte and last set, and is always allowed. Write a rule's
// bytes before enabling it with its length. The block takes one item per
// clock while in_ready is high; a result is registered onto out_valid when
// its last item leaves the compare stage. Each rule has its own byte bank
// read at the current path position, so one byte per cycle is compared
// against every rule at once. The input side stalls only when a result item
// waits in the output register and the next item in the compare stage would
// produce another one. No clearing pass is needed after reset: rule lengths
// reset to zero, and rule bytes are defined once written.
module multi_prefix_path_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [mppm_pkg::IDX_W-1:0]  in_rule_index,
  input  logic [mppm_pkg::BPOS_W-1:0] in_byte_position,
  input  logic [mppm_pkg::DATA_W-1:0] in_data_byte,
  input  logic [6:0]                  in_new_length,
  input  logic                        in_last,
  input  logic                        in_no_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_allowed,
  output logic [mppm_pkg::IDX_W-1:0]  out_matched_rule
);
  import mppm_pkg::*;

  op_t                          in_op_e;
  logic                         accept;
  logic                         consume;
  logic [LEN_W-1:0]             sat_len;
  logic                         byte_in_range;

  logic [LEN_W-1:0]             path_pos_r;
  logic [LEN_W-1:0]             path_pos_nxt;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  item_t                        s1_item_r;
  item_t                        s1_item_nxt;
  logic                         s1_go;
  logic                         s1_fire;
  logic                         res_fire;

  logic [RULES-1:0][DATA_W-1:0] rd_bytes;
  logic                         res_allowed;
  logic [IDX_W-1:0]             res_rule;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         out_allowed_r;
  logic [IDX_W-1:0]             out_rule_r;

  assign in_op_e = op_t'(in_op);

  // Only a path end can be held back, and only by a waiting result
  assign res_fire = s1_valid_r && (s1_item_r.op == OP_PATH) && s1_item_r.last;
  assign s1_go    = !((s1_item_r.op == OP_PATH) && s1_item_r.last) ||
                    !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  assign byte_in_range = LEN_W'(in_byte_position) < LEN_W'(RULE_BYTES);
  assign sat_len = (in_new_length > 7'(RULE_BYTES)) ? LEN_W'(RULE_BYTES)
                                                    : LEN_W'(in_new_length);
  // Bytes beyond the longest possible rule are not compared
  assign consume = !in_no_byte && (path_pos_r < LEN_W'(RULE_BYTES));

  // Advance the path position as items enter; it addresses the bank reads
  always_comb begin
    path_pos_nxt = path_pos_r;
    if (accept && (in_op_e == OP_PATH)) begin
      if (in_last) begin
        path_pos_nxt = '0;
      end else begin
        path_pos_nxt = path_pos_r + LEN_W'(consume);
      end
    end
  end

  always_comb begin
    s1_item_nxt.op      = in_op_e;
    s1_item_nxt.idx     = in_rule_index;
    s1_item_nxt.len     = sat_len;
    s1_item_nxt.data    = in_data_byte;
    s1_item_nxt.last    = in_last;
    s1_item_nxt.consume = consume;
    s1_item_nxt.pos     = path_pos_r;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire && s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // One byte bank per rule: write from rule-byte items, read at the path position
  for (genvar g = 0; g < RULES; g++) begin : g_bank
    logic bank_we;
    assign bank_we = accept && (in_op_e == OP_WR_BYTE) && byte_in_range &&
                     (in_rule_index == IDX_W'(g));
    mppm_bank u_bank (
      .clk   (clk),
      .we    (bank_we),
      .waddr (ADDR_W'(in_byte_position)),
      .wdata (in_data_byte),
      .re    (accept),
      .raddr (path_pos_r[ADDR_W-1:0]),
      .rdata (rd_bytes[g])
    );
  end

  mppm_match u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .item        (s1_item_r),
    .rd_bytes    (rd_bytes),
    .res_allowed (res_allowed),
    .res_rule    (res_rule)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_pos_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      path_pos_r  <= path_pos_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
    if (res_fire && s1_go) begin
      out_allowed_r <= res_allowed;
      out_rule_r    <= res_rule;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_allowed      = out_allowed_r;
  assign out_matched_rule = out_rule_r;

endmodule

// ===== hdl/mppm_bank.sv =====
// Byte store of one rule: one write port, one read port with registered data.
// Depends on mppm_pkg.
module mppm_bank (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mppm_pkg::ADDR_W-1:0] waddr,
  input  logic [mppm_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [mppm_pkg::ADDR_W-1:0] raddr,
  output logic [mppm_pkg::DATA_W-1:0] rdata
);
  import mppm_pkg::*;

  logic [DATA_W-1:0] mem [RULE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mppm_match.sv =====
// Compare stage: rule lengths, live-candidate flags and the lowest-index match.
// Depends on mppm_pkg.
module mppm_match (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      fire,
  input  mppm_pkg::item_t                           item,
  input  logic [mppm_pkg::RULES-1:0][mppm_pkg::DATA_W-1:0] rd_bytes,
  output logic                                      res_allowed,
  output logic [mppm_pkg::IDX_W-1:0]                res_rule
);
  import mppm_pkg::*;

  logic [LEN_W-1:0] len_r   [RULES];
  logic [LEN_W-1:0] len_nxt [RULES];
  logic [RULES-1:0] alive_r;
  logic [RULES-1:0] alive_nxt;
  logic [RULES-1:0] alive_cmp;
  logic [RULES-1:0] hit_vec;
  logic [LEN_W-1:0] pos_after;

  assign pos_after = item.pos + LEN_W'(item.consume);

  // Drop every candidate whose byte at this position differs
  always_comb begin
    for (int i = 0; i < RULES; i++) begin
      alive_cmp[i] = alive_r[i] &&
                     !(item.consume && (item.pos < len_r[i]) &&
                       (rd_bytes[i] != item.data));
      hit_vec[i]   = (len_r[i] != '0) && (len_r[i] <= pos_after) && alive_cmp[i];
    end
  end

  // Lowest matching index wins
  always_comb begin
    res_allowed = 1'b1;
    res_rule    = '0;
    for (int i = RULES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        res_allowed = 1'b0;
        res_rule    = IDX_W'(i);
      end
    end
  end

  always_comb begin
    alive_nxt = alive_r;
    for (int i = 0; i < RULES; i++) begin
      len_nxt[i] = len_r[i];
    end
    if (fire) begin
      case (item.op)
        OP_SET_LEN: begin
          for (int i = 0; i < RULES; i++) begin
            if (item.idx == IDX_W'(i)) begin
              len_nxt[i] = item.len;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < RULES; i++) begin
            len_nxt[i] = '0;
          end
        end
        OP_PATH: begin
          alive_nxt = item.last ? '1 : alive_cmp;
        end
        default: begin
          alive_nxt = alive_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '1;
      for (int i = 0; i < RULES; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      alive_r <= alive_nxt;
      for (int i = 0; i < RULES; i++) begin
        len_r[i] <= len_nxt[i];
      end
    end
  end

endmodule
